[rtl/svm_pkg.sv]
package svm_pkg;

    localparam int StackDepth = 256;
    localparam int RegCount   = 10;
    localparam int WordBits   = 32;
    localparam int SpBits     = $clog2(StackDepth);
    localparam int RegBits    = $clog2(RegCount);

    typedef logic [WordBits-1:0] word_t;
    typedef logic [SpBits-1:0]   sidx_t;
    typedef logic [RegBits-1:0]  ridx_t;

    localparam ridx_t R_A   = ridx_t'(0);
    localparam ridx_t R_B   = ridx_t'(1);
    localparam ridx_t R_C   = ridx_t'(2);
    localparam ridx_t R_IP  = ridx_t'(6);
    localparam ridx_t R_SP  = ridx_t'(7);
    localparam ridx_t R_JMP = ridx_t'(8);
    localparam ridx_t R_RUN = ridx_t'(9);

    typedef enum logic [4:0] {
        OP_HLT = 5'd0, OP_PSH = 5'd1, OP_POP = 5'd2, OP_ADD = 5'd3,
        OP_MUL = 5'd4, OP_DIV = 5'd5, OP_SUB = 5'd6, OP_MOD = 5'd7,
        OP_SLT = 5'd8, OP_MOV = 5'd9, OP_SET = 5'd10, OP_LOG = 5'd11,
        OP_LOGR = 5'd12, OP_LOGS = 5'd13, OP_IF = 5'd14, OP_IFN = 5'd15,
        OP_GLD = 5'd16, OP_GPT = 5'd17, OP_NOP = 5'd18
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_OPCODE = 2'd1, ERR_DIVZERO = 2'd2, ERR_REGIDX = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RDREG, ST_RDSTK1, ST_RDSTK2, ST_DIV, ST_EXEC, ST_WRREG,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [4:0]  func;
        logic [31:0] arg_one;
        logic [31:0] arg_two;
        logic [31:0] arg_three;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_ip;
        logic        halted;
        logic        log_valid;
        logic [31:0] log_value;
        logic [1:0]  error_code;
    } out_item_t;

    // divider request and answer
    typedef struct packed {
        logic  start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quo;
        word_t rem;
    } div_rsp_t;

    function automatic word_t sext32(logic [31:0] a);
        return word_t'($signed(a));
    endfunction

endpackage

[rtl/stack_vm_instruction_executor.sv]
// Executes one stack machine instruction per transfer on s_: the opcode and
// the three program words after it. The result shows on m_ after the steps
// stack top read, second stack read, capture, execute with stack write back,
// register write back and result capture. While the machine runs, DIV and MOD
// also wait for the bit-serial divider. After reset the stack memory is cleared
// before the first transfer is taken. The result is held on m_ until taken;
// the next instruction is accepted from the cycle after that, so a new
// instruction is not taken while the last one is in flight or its result waits.
module stack_vm_instruction_executor
    import svm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    state_t    state_reg, state_next;
    in_item_t  item_reg;
    sidx_t     clr_reg;
    word_t     rf_reg [RegCount];
    word_t     x_reg, y_reg, r1_reg;
    logic      bad1_reg, bad2_reg;
    out_item_t out_reg;
    logic      m_valid_reg;
    logic      live_reg;

    op_t       op;
    word_t     sp, a1w, a2w, a3w;
    logic      a1ok, a2ok;
    ridx_t     a1i, a2i;
    word_t     rd1, rd2;
    word_t     s1, s2, g1;

    logic      st_we;
    sidx_t     st_waddr, st_raddr;
    word_t     st_wdata, st_rdata;
    div_req_t  dreq;
    div_rsp_t  drsp;

    logic      wb_en;
    ridx_t     wb_idx;
    word_t     wb_val;
    logic      jump_taken;
    word_t     ip_base, ip_next;
    logic [1:0] ip_step;

    assign op   = op_t'(item_reg.func);
    assign sp   = rf_reg[R_SP];
    assign a1w  = sext32(item_reg.arg_one);
    assign a2w  = sext32(item_reg.arg_two);
    assign a3w  = sext32(item_reg.arg_three);
    assign a1ok = item_reg.arg_one < 32'(RegCount);
    assign a2ok = item_reg.arg_two < 32'(RegCount);
    assign a1i  = ridx_t'(item_reg.arg_one);
    assign a2i  = ridx_t'(item_reg.arg_two);
    // the jump flag is cleared by every executed step, so it reads as zero
    assign rd1  = a1ok ? ((a1i == R_JMP) ? '0 : rf_reg[a1i]) : '0;
    assign rd2  = a2ok ? ((a2i == R_JMP) ? '0 : rf_reg[a2i]) : '0;
    // SLT reads its registers after the stack pointer drops
    assign s1   = (a1ok && a1i == R_SP) ? sp - 1'b1 : rd1;
    assign s2   = (a2ok && a2i == R_SP) ? sp - 1'b1 : rd2;
    // GLD reads its register after the stack pointer and IP advance
    assign g1   = (a1ok && a1i == R_SP) ? sp + 1'b1
                : (a1ok && a1i == R_IP) ? rf_reg[R_IP] + 1'b1 : rd1;

    svm_stack_ram u_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    svm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    logic is_arith, is_div;
    assign is_arith = op == OP_ADD || op == OP_MUL || op == OP_DIV || op == OP_SUB
                      || op == OP_MOD;
    assign is_div   = op == OP_DIV || op == OP_MOD;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == sidx_t'(StackDepth - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_RDREG;
            ST_RDREG:  state_next = ST_RDSTK1;
            ST_RDSTK1: state_next = ST_RDSTK2;
            ST_RDSTK2: state_next = (is_div && rf_reg[R_RUN] != '0) ? ST_DIV : ST_EXEC;
            ST_DIV:    if (drsp.done) state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_WRREG;
            ST_WRREG:  state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // stack read address: top first, then second or LOGS offset
    always_comb begin
        st_raddr = sidx_t'(sp);
        unique case (state_reg)
            ST_RDREG:  st_raddr = sidx_t'(sp);
            ST_RDSTK1: st_raddr = (op == OP_LOGS) ? sidx_t'(sp - rd1)
                                                  : sidx_t'(sp - 1'b1);
            default:   st_raddr = sidx_t'(sp);
        endcase
    end

    // divider launch and result
    word_t arith_z;
    logic  divz;
    always_comb begin
        dreq.start = state_reg == ST_RDSTK2 && is_div && rf_reg[R_RUN] != '0;
        dreq.num   = (op == OP_DIV) ? st_rdata : x_reg;
        dreq.den   = (op == OP_DIV) ? x_reg : st_rdata;
        divz       = (op == OP_DIV) ? (x_reg == '0) : (y_reg == '0);
        unique case (op)
            OP_ADD:  arith_z = y_reg + x_reg;
            OP_SUB:  arith_z = y_reg - x_reg;
            OP_MUL:  arith_z = word_t'(y_reg * x_reg);
            OP_DIV:  arith_z = divz ? '0 : drsp.quo;
            default: arith_z = divz ? '0 : drsp.rem;
        endcase
    end

    // stack write: clear sweep or instruction write back in ST_EXEC
    logic run;
    assign run = rf_reg[R_RUN] != '0;
    always_comb begin
        st_we    = 1'b0;
        st_waddr = clr_reg;
        st_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            st_we = 1'b1;
        end else if (state_reg == ST_EXEC && run) begin
            if (op == OP_PSH || op == OP_GLD) begin
                st_we    = 1'b1;
                st_waddr = sidx_t'(sp + 1'b1);
                st_wdata = (op == OP_PSH) ? a1w : g1;
            end else if (is_arith) begin
                st_we    = 1'b1;
                st_waddr = sidx_t'(sp - 1'b1);
                st_wdata = arith_z;
            end else if (op == OP_SLT) begin
                st_we    = 1'b1;
                st_waddr = sidx_t'(sp - 1'b1);
                st_wdata = word_t'($signed(s1) < $signed(s2));
            end
        end
    end

    // register write back and next IP for ST_WRREG
    always_comb begin
        wb_en      = 1'b0;
        wb_idx     = a1i;
        wb_val     = a2w;
        jump_taken = (op == OP_IF || op == OP_IFN) && ((r1_reg == a2w) == (op == OP_IF));
        ip_base    = rf_reg[R_IP];
        ip_step    = 2'd0;
        unique case (op)
            OP_MOV: begin
                wb_en   = a2ok;
                wb_idx  = a2i;
                wb_val  = r1_reg;
                ip_step = 2'd2;
            end
            OP_SET: begin
                wb_en   = a1ok;
                ip_step = 2'd2;
            end
            OP_GPT: begin
                wb_en   = a1ok;
                wb_val  = x_reg;
                ip_step = 2'd1;
            end
            OP_PSH, OP_LOG, OP_LOGR, OP_LOGS, OP_GLD: ip_step = 2'd1;
            OP_SLT:        ip_step = 2'd2;
            OP_IF, OP_IFN: ip_step = 2'd3;
            default: ;
        endcase
        // a write to IP lands before the step advance
        if (wb_en && wb_idx == R_IP) ip_base = wb_val;
        // a nonzero jump flag written by the step suppresses the final increment
        ip_next = ip_base + word_t'(ip_step)
                  + word_t'(!(wb_en && wb_idx == R_JMP && wb_val != '0));
    end

    // register file update and result capture in ST_EXEC, ST_WRREG and ST_OUT
    logic [1:0] err;
    logic       logv;
    word_t      logval;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            live_reg    <= 1'b0;
            for (int i = 0; i < RegCount; i++) begin
                if (ridx_t'(i) == R_SP) rf_reg[i] <= '1;
                else if (ridx_t'(i) == R_RUN) rf_reg[i] <= word_t'(1);
                else rf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_RDSTK1) x_reg <= st_rdata;
            if (state_reg == ST_RDSTK2) y_reg <= st_rdata;
            if (state_reg == ST_EXEC) live_reg <= run;
            if (state_reg == ST_EXEC && run) begin
                rf_reg[R_JMP] <= '0;
                r1_reg <= rd1;
                unique case (op)
                    OP_HLT: rf_reg[R_RUN] <= '0;
                    OP_PSH, OP_GLD: rf_reg[R_SP] <= sp + 1'b1;
                    OP_POP, OP_SLT: rf_reg[R_SP] <= sp - 1'b1;
                    OP_ADD, OP_MUL, OP_DIV, OP_SUB, OP_MOD: begin
                        rf_reg[R_A]  <= x_reg;
                        rf_reg[R_B]  <= y_reg;
                        rf_reg[R_C]  <= arith_z;
                        rf_reg[R_SP] <= sp - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_WRREG && live_reg) begin
                if (wb_en && wb_idx != R_IP) rf_reg[wb_idx] <= wb_val;
                if (jump_taken) begin
                    rf_reg[R_IP]  <= a3w;
                    rf_reg[R_JMP] <= word_t'(1);
                end else begin
                    rf_reg[R_IP] <= ip_next;
                end
            end
        end
        if (s_valid && s_ready) item_reg <= s_data;
        if (state_reg == ST_EXEC) begin
            out_reg.error_code <= err;
            out_reg.log_valid  <= logv;
            out_reg.log_value  <= logval[31:0];
        end
        if (state_reg == ST_OUT) begin
            out_reg.next_ip <= rf_reg[R_IP][31:0];
            out_reg.halted  <= rf_reg[R_RUN] == '0;
        end
    end

    // error and log
    always_comb begin
        err    = ERR_NONE;
        logv   = 1'b0;
        logval = '0;
        if (run) begin
            unique case (op)
                OP_DIV, OP_MOD: if (divz) err = ERR_DIVZERO;
                OP_SLT:         if (!a1ok || !a2ok) err = ERR_REGIDX;
                OP_MOV:         if (!a1ok || !a2ok) err = ERR_REGIDX;
                OP_SET, OP_GLD, OP_GPT, OP_IF, OP_IFN:
                                if (!a1ok) err = ERR_REGIDX;
                OP_LOG: begin
                    logv = 1'b1;  logval = a1w;
                end
                OP_LOGR: begin
                    logv = 1'b1;  logval = rd1;
                    if (!a1ok) err = ERR_REGIDX;
                end
                OP_LOGS: begin
                    logv = 1'b1;  logval = y_reg;
                    if (!a1ok) err = ERR_REGIDX;
                end
                OP_HLT, OP_PSH, OP_POP, OP_ADD, OP_MUL, OP_SUB, OP_NOP: ;
                default: err = ERR_OPCODE;
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    property p_div_only_for_div;
        @(posedge aclk) disable iff (!aresetn) dreq.start |-> is_div;
    endproperty
    assert property (p_div_only_for_div) else $error("divider started for non divide");

    property p_no_accept_in_clear;
        @(posedge aclk) disable iff (!aresetn) state_reg == ST_CLEAR |-> !s_ready;
    endproperty
    assert property (p_no_accept_in_clear) else $error("accept during clear");

    property p_result_after_wb;
        @(posedge aclk) disable iff (!aresetn) state_reg == ST_OUT |=> m_valid_reg;
    endproperty
    assert property (p_result_after_wb) else $error("result not raised");

    property p_result_held;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty
    assert property (p_result_held) else $error("pending result changed");

endmodule

[rtl/svm_divider.sv]
module svm_divider
    import svm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CntBits = $clog2(WordBits + 1);

    logic               busy_reg, busy_next;
    logic [CntBits-1:0] cnt_reg, cnt_next;
    word_t              q_reg, q_next;
    word_t              r_reg, r_next;
    word_t              d_reg, d_next;
    logic               nn_reg, nn_next, qn_reg, qn_next;
    logic               done_reg, done_next;
    logic [WordBits:0]  trial;
    word_t              rsh;

    // one restoring step per cycle on magnitudes
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        nn_next   = nn_reg;
        qn_next   = qn_reg;
        done_next = 1'b0;
        rsh       = {r_reg[WordBits-2:0], q_reg[WordBits-1]};
        trial     = {1'b0, rsh} - {1'b0, d_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CntBits'(WordBits);
            nn_next   = req.num[WordBits-1];
            qn_next   = req.num[WordBits-1] ^ req.den[WordBits-1];
            q_next    = req.num[WordBits-1] ? -req.num : req.num;
            d_next    = req.den[WordBits-1] ? -req.den : req.den;
            r_next    = '0;
        end else if (busy_reg) begin
            if (r_reg[WordBits-1] == 1'b0 && !trial[WordBits]) begin
                r_next = trial[WordBits-1:0];
                q_next = {q_reg[WordBits-2:0], 1'b1};
            end else if (r_reg[WordBits-1]) begin
                r_next = rsh - d_reg;
                q_next = {q_reg[WordBits-2:0], 1'b1};
            end else begin
                r_next = rsh;
                q_next = {q_reg[WordBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        nn_reg <= nn_next;
        qn_reg <= qn_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = qn_reg ? -q_reg : q_reg;
    assign rsp.rem  = nn_reg ? -r_reg : r_reg;

endmodule

[rtl/svm_stack_ram.sv]
module svm_stack_ram
    import svm_pkg::*;
(
    input  logic  aclk,
    input  logic  we,
    input  sidx_t waddr,
    input  word_t wdata,
    input  sidx_t raddr,
    output word_t rdata
);

    word_t mem [StackDepth];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
